[sv/histeq_pkg.sv]
package histeq_pkg;

	localparam int PIX_W = 8;
	localparam int MAP_DEPTH = 256;
	localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

	// Request kinds carried on the slave tuser bit.
	localparam logic REQ_ACCUM = 1'b0;
	localparam logic REQ_REMAP = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CUM,
		ST_DIV
	} walk_state_t;

	typedef struct packed {
		logic             en;
		logic [PIX_W-1:0] addr;
		logic [PIX_W-1:0] data;
	} map_wr_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

[sv/histeq_div.sv]
module histeq_div #(
	parameter int NUM_W = 41,
	parameter int DEN_W = 23
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [NUM_W-1:0]                 num,
	input  logic [DEN_W-1:0]                 den,
	output histeq_pkg::div_sts_t             sts,
	output logic [histeq_pkg::PIX_W-1:0]     quot
);
	import histeq_pkg::*;

	localparam int DSH_W  = DEN_W + PIX_W;
	localparam int REM_W  = (NUM_W > DSH_W) ? NUM_W : DSH_W;
	localparam int STEP_W = $clog2(PIX_W + 1);
	localparam int QI_W   = $clog2(PIX_W);
	localparam logic [STEP_W-1:0] STEP_SAT = STEP_W'(PIX_W);

	logic [REM_W-1:0]  rem_q;
	logic [REM_W-1:0]  dsh_q;
	logic [STEP_W-1:0] step_q;
	logic [PIX_W-1:0]  quot_q;
	logic              busy_q;
	logic              done_q;
	logic              ge;

	assign ge = rem_q >= dsh_q;

	// The first step only tests for a quotient of 256 or more, which clamps to the top level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_SAT;
			end else if (busy_q) begin
				if ((step_q == STEP_SAT && ge) || step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= REM_W'(num);
			dsh_q  <= REM_W'({den, {PIX_W{1'b0}}});
			quot_q <= '0;
		end else if (busy_q) begin
			if (step_q == STEP_SAT) begin
				if (ge) begin
					quot_q <= PIX_MAX;
				end
			end else if (ge) begin
				rem_q                  <= rem_q - dsh_q;
				quot_q[step_q[QI_W-1:0]] <= 1'b1;
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	assign sts  = '{busy: busy_q, done: done_q};
	assign quot = quot_q;

endmodule

[sv/histeq_bins.sv]
module histeq_bins #(
	parameter int DEPTH = 256,
	parameter int AW    = 8,
	parameter int DW    = 23
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);
	logic [DW-1:0]    mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [DW-1:0]    rd_q;
	logic             rd_vld_q;

	// Read returns the old contents when the same entry is written in the same cycle.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// A bin never written since reset reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

[sv/histeq_map.sv]
module histeq_map (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [histeq_pkg::PIX_W-1:0] rd_addr,
	output logic [histeq_pkg::PIX_W-1:0] rd_data,
	input  histeq_pkg::map_wr_t          wr
);
	import histeq_pkg::*;

	logic [PIX_W-1:0]     mem [MAP_DEPTH];
	logic [MAP_DEPTH-1:0] vld_q;
	logic [PIX_W-1:0]     rd_q;
	logic [PIX_W-1:0]     rd_addr_q;
	logic                 rd_vld_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q      <= mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Entries not yet rebuilt since reset hold the identity mapping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : rd_addr_q;

endmodule

[sv/histogram_equalization_core.sv]
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tdata: pixel; tuser: req_type; tlast: last
// m_*      out  m_tvalid/m_tready  tdata: out_pixel (remap transactions only)
//
// Accumulate and remap transactions are taken one per cycle; a remap result appears in the
// cycle after its transaction and waits in the output register until taken, holding the input.
// After the last accumulate transaction the input stalls while it is written back and then for
// the map build: per gray level one bin read, one cumulative add and a bit-serial divide.
// After reset the histogram reads as zero and the map as identity; no clearing pass.
module histogram_equalization_core #(
	parameter int GRAY_LEVELS      = 256,
	parameter int MAX_FRAME_PIXELS = 4194304
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] pixel
	input  logic       s_tuser,   // [0] req_type
	input  logic       s_tlast,   // last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [7:0] out_pixel
);
	import histeq_pkg::*;

	localparam int CNT_W  = $clog2(longint'(MAX_FRAME_PIXELS) + 1);
	localparam int BIN_AW = $clog2(GRAY_LEVELS);
	localparam int CUM_W  = $clog2(longint'(GRAY_LEVELS) * longint'(MAX_FRAME_PIXELS) + 1);
	localparam int NUM_W  = $clog2(longint'(GRAY_LEVELS) * longint'(GRAY_LEVELS)
		* longint'(MAX_FRAME_PIXELS) + 1);
	localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_FRAME_PIXELS);
	localparam logic [BIN_AW-1:0] BIN_LAST = BIN_AW'(GRAY_LEVELS - 1);

	walk_state_t       state_q;
	walk_state_t       state_d;

	logic              accept;
	logic              acc_in;
	logic              remap_in;
	logic [BIN_AW-1:0] bin_addr;

	logic              acc_vld_s1;
	logic              last_s1;
	logic [BIN_AW-1:0] addr_s1;

	logic              fwd_vld_q;
	logic [BIN_AW-1:0] fwd_addr_q;
	logic [CNT_W-1:0]  fwd_data_q;

	logic              bin_rd_en;
	logic [BIN_AW-1:0] bin_rd_addr;
	logic [CNT_W-1:0]  bin_rd_data;
	logic              bin_wr_en;
	logic [BIN_AW-1:0] bin_wr_addr;
	logic [CNT_W-1:0]  bin_wr_data;
	logic [CNT_W-1:0]  bin_old;
	logic [CNT_W-1:0]  bin_new;

	logic [CNT_W-1:0]  total_q;
	logic [CUM_W-1:0]  cum_q;
	logic [CUM_W-1:0]  cum_next;
	logic [BIN_AW-1:0] idx_q;
	logic              walk_end;

	logic              div_start;
	logic [NUM_W-1:0]  div_num;
	div_sts_t          div_sts;
	logic [PIX_W-1:0]  div_quot;
	map_wr_t           map_wr;
	logic              m_tvalid_q;

	assign accept   = s_tvalid & s_tready;
	assign acc_in   = accept & (s_tuser == REQ_ACCUM);
	assign remap_in = accept & (s_tuser == REQ_REMAP);

	// Pixels at or above the level count land in the top bin.
	assign bin_addr = ({1'b0, s_tdata} >= 9'(GRAY_LEVELS)) ? BIN_LAST : s_tdata[BIN_AW-1:0];

	assign s_tready = (state_q == ST_IDLE) && !(acc_vld_s1 && last_s1)
		&& (!m_tvalid_q || m_tready);

	// Accumulate pipeline: read the bin at acceptance, increment and write back in the next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_vld_s1 <= 1'b0;
			fwd_vld_q  <= 1'b0;
		end else begin
			acc_vld_s1 <= acc_in;
			fwd_vld_q  <= acc_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			addr_s1 <= bin_addr;
			last_s1 <= s_tlast;
		end
		fwd_addr_q <= addr_s1;
		fwd_data_q <= bin_new;
	end

	// The read issued beside the previous write-back misses it, so that value is forwarded.
	assign bin_old = (fwd_vld_q && fwd_addr_q == addr_s1) ? fwd_data_q : bin_rd_data;
	assign bin_new = (bin_old < CNT_MAX) ? bin_old + 1'b1 : bin_old;

	// The walk reads each bin and clears it with the same access.
	assign bin_rd_en   = acc_in || (state_q == ST_READ);
	assign bin_rd_addr = (state_q == ST_READ) ? idx_q : bin_addr;
	assign bin_wr_en   = acc_vld_s1 || (state_q == ST_READ);
	assign bin_wr_addr = acc_vld_s1 ? addr_s1 : idx_q;
	assign bin_wr_data = acc_vld_s1 ? bin_new : '0;

	histeq_bins #(
		.DEPTH (GRAY_LEVELS),
		.AW    (BIN_AW),
		.DW    (CNT_W)
	) u_bins (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (bin_rd_en),
		.rd_addr (bin_rd_addr),
		.rd_data (bin_rd_data),
		.wr_en   (bin_wr_en),
		.wr_addr (bin_wr_addr),
		.wr_data (bin_wr_data)
	);

	assign cum_next  = cum_q + CUM_W'(bin_rd_data);
	assign div_num   = NUM_W'(cum_next) * NUM_W'(GRAY_LEVELS);
	assign div_start = (state_q == ST_CUM);
	assign walk_end  = (state_q == ST_DIV) && div_sts.done && (idx_q == BIN_LAST);

	histeq_div #(
		.NUM_W (NUM_W),
		.DEN_W (CNT_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (total_q),
		.sts    (div_sts),
		.quot   (div_quot)
	);

	assign map_wr = '{
		en:   (state_q == ST_DIV) && div_sts.done,
		addr: PIX_W'(idx_q),
		data: div_quot
	};

	histeq_map u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (remap_in),
		.rd_addr (s_tdata),
		.rd_data (m_tdata),
		.wr      (map_wr)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc_vld_s1 && last_s1) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_CUM;
			end
			ST_CUM: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_sts.done) begin
					state_d = (idx_q == BIN_LAST) ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= '0;
			cum_q      <= '0;
			idx_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (acc_vld_s1 && total_q < CNT_MAX) begin
				total_q <= total_q + 1'b1;
			end else if (walk_end) begin
				total_q <= '0;
			end
			if (state_q == ST_CUM) begin
				cum_q <= cum_next;
			end else if (walk_end) begin
				cum_q <= '0;
			end
			if (walk_end) begin
				idx_q <= '0;
			end else if (state_q == ST_DIV && div_sts.done) begin
				idx_q <= idx_q + 1'b1;
			end
			if (remap_in) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;

`ifndef SYNTHESIS
	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_tready)
		else $error("input ready during map build");

	a_no_acc_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !acc_vld_s1)
		else $error("bin write-back collides with map build");

	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> div_sts.busy)
		else $error("divider did not start");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CNT_MAX)
		else $error("pixel total beyond frame bound");
`endif

endmodule
